// ===== src/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared types and microcode codes for the trial division prime tester
// ----------------------------------------------------------------------------
package tdpt_pkg;

	// program counter of the sequencer
	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	// step addresses of the microprogram
	localparam pc_t STEP_WAIT     = 4'd0;
	localparam pc_t STEP_CHECK    = 4'd1;
	localparam pc_t STEP_DIV_INIT = 4'd2;
	localparam pc_t STEP_DIV_STEP = 4'd3;
	localparam pc_t STEP_BOUND    = 4'd4;
	localparam pc_t STEP_REM      = 4'd5;
	localparam pc_t STEP_NEXT_D   = 4'd6;
	localparam pc_t STEP_TRUE     = 4'd7;
	localparam pc_t STEP_FALSE    = 4'd8;
	localparam pc_t STEP_EMIT     = 4'd9;

	// datapath action of one step
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_DIV_INIT,
		ACT_DIV_STEP,
		ACT_INC_D,
		ACT_RES_TRUE,
		ACT_RES_FALSE,
		ACT_EMIT
	} act_t;

	// jump condition of one step
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_LESS_TWO,
		COND_DIV_BUSY,
		COND_PAST_BOUND,
		COND_REM_ZERO,
		COND_OUT_BUSY
	} cond_t;

	// one control word of the program table
	typedef struct packed {
		act_t  act;
		cond_t cond;
		pc_t   target;
	} ctrl_word_t;

	// status flags seen by the sequencer
	typedef struct packed {
		logic no_input;
		logic less_two;
		logic div_busy;
		logic past_bound;
		logic rem_zero;
		logic out_busy;
	} status_t;

endpackage

// ===== src/tdpt_seq.sv =====
// ----------------------------------------------------------------------------
// tdpt_seq
// microprogram sequencer: step counter, program table and conditional jumps
// ----------------------------------------------------------------------------
module tdpt_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  tdpt_pkg::status_t status,
	output tdpt_pkg::act_t   act,
	output tdpt_pkg::pc_t    pc
);
	import tdpt_pkg::*;

	pc_t        pc_q;
	ctrl_word_t cw;
	logic       take;

	// program table
	function automatic ctrl_word_t program_word(input pc_t addr);
		ctrl_word_t w;
		unique case (addr)
			STEP_WAIT:     w = '{ACT_LOAD,      COND_NO_INPUT,   STEP_WAIT};
			STEP_CHECK:    w = '{ACT_NONE,      COND_LESS_TWO,   STEP_FALSE};
			STEP_DIV_INIT: w = '{ACT_DIV_INIT,  COND_NEVER,      STEP_WAIT};
			STEP_DIV_STEP: w = '{ACT_DIV_STEP,  COND_DIV_BUSY,   STEP_DIV_STEP};
			STEP_BOUND:    w = '{ACT_NONE,      COND_PAST_BOUND, STEP_TRUE};
			STEP_REM:      w = '{ACT_NONE,      COND_REM_ZERO,   STEP_FALSE};
			STEP_NEXT_D:   w = '{ACT_INC_D,     COND_ALWAYS,     STEP_DIV_INIT};
			STEP_TRUE:     w = '{ACT_RES_TRUE,  COND_ALWAYS,     STEP_EMIT};
			STEP_FALSE:    w = '{ACT_RES_FALSE, COND_NEVER,      STEP_WAIT};
			STEP_EMIT:     w = '{ACT_EMIT,      COND_OUT_BUSY,   STEP_EMIT};
			default:       w = '{ACT_NONE,      COND_ALWAYS,     STEP_WAIT};
		endcase
		return w;
	endfunction

	assign cw = program_word(pc_q);

	// jump condition select
	always_comb begin
		unique case (cw.cond)
			COND_NEVER:      take = 1'b0;
			COND_ALWAYS:     take = 1'b1;
			COND_NO_INPUT:   take = status.no_input;
			COND_LESS_TWO:   take = status.less_two;
			COND_DIV_BUSY:   take = status.div_busy;
			COND_PAST_BOUND: take = status.past_bound;
			COND_REM_ZERO:   take = status.rem_zero;
			COND_OUT_BUSY:   take = status.out_busy;
			default:         take = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else if (take) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_t'(pc_q + 1'b1);
		end
	end

	assign act = cw.act;
	assign pc  = pc_q;

endmodule

// ===== src/tdpt_datapath.sv =====
// ----------------------------------------------------------------------------
// tdpt_datapath
// candidate and divisor registers with a restoring divider, one bit a step
// ----------------------------------------------------------------------------
module tdpt_datapath #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  tdpt_pkg::act_t act,
	input  logic [W-1:0] cand,
	output logic         less_two,
	output logic         div_busy,
	output logic         past_bound,
	output logic         rem_zero,
	output logic         res
);
	import tdpt_pkg::*;

	localparam int CNT_W = (W > 1) ? $clog2(W) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

	logic [W-1:0]     n_q;
	logic [W-1:0]     d_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             res_q;

	logic [W:0]       trial;
	logic [W:0]       diff;
	logic             fits;

	// one restoring division step
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = ~diff[W];

	// status towards the sequencer
	assign less_two   = n_q[W-1] | (n_q[W-1:1] == '0);
	assign div_busy   = (cnt_q != CNT_LAST);
	assign past_bound = (d_q > quo_q);
	assign rem_zero   = (rem_q == '0);
	assign res        = res_q;

	// result flag, the only register here with a reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= 1'b0;
		end else if (act == ACT_RES_TRUE) begin
			res_q <= 1'b1;
		end else if (act == ACT_RES_FALSE) begin
			res_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (act)
			ACT_LOAD: begin
				n_q <= cand;
				d_q <= W'(2);
			end
			ACT_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= n_q;
				cnt_q <= '0;
			end
			ACT_DIV_STEP: begin
				rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
				quo_q <= {quo_q[W-2:0], fits};
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end
			ACT_INC_D: begin
				d_q <= W'(d_q + 1'b1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/trial_division_prime_test_core.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// primality test of one signed word by trial division under microcode
// ----------------------------------------------------------------------------
// use:
//   input channel cand_valid / cand_stall carries one candidate word, taken as
//   a VALUE_WIDTH-bit two's complement value. output channel res_valid /
//   res_stall returns one is_prime word for each candidate, in order.
//   a word moves on a rising edge with valid high and stall low.
// sequence:
//   negative, zero or one: the check step goes straight to the false result
//   and the emit step. otherwise each divisor tried takes one setup step,
//   VALUE_WIDTH restoring divider steps, a bound test, a remainder test and
//   an increment, and divisors run from 2 up to about sqrt(candidate), so a
//   large prime at 32 bits tries about 46341 divisors.
// throughput:
//   one candidate at a time; the shared divider loop sets the rate.
//   cand_stall is low only while the sequencer waits for a new word.
// reset:
//   arst_n clears the step counter and the output valid at once.
// stall:
//   a result held by res_stall stays in the output register; the next
//   candidate is accepted and worked on meanwhile, and waits at the end
//   until the output register is free.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cand_valid,
	output logic                          cand_stall,
	input  logic signed [VALUE_WIDTH-1:0] candidate,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          is_prime
);
	import tdpt_pkg::*;

	status_t status;
	act_t    act;
	pc_t     pc;
	logic    less_two;
	logic    div_busy;
	logic    past_bound;
	logic    rem_zero;
	logic    res;
	logic    res_valid_q;
	logic    is_prime_q;
	logic    out_busy;

	// output register occupancy
	assign out_busy = res_valid_q & res_stall;

	// status gathered for the sequencer
	assign status = '{
		no_input:   ~cand_valid,
		less_two:   less_two,
		div_busy:   div_busy,
		past_bound: past_bound,
		rem_zero:   rem_zero,
		out_busy:   out_busy
	};

	tdpt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.act    (act),
		.pc     (pc)
	);

	tdpt_datapath #(
		.W (VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.act        (act),
		.cand       (candidate),
		.less_two   (less_two),
		.div_busy   (div_busy),
		.past_bound (past_bound),
		.rem_zero   (rem_zero),
		.res        (res)
	);

	// input handshake: open only in the wait step
	assign cand_stall = (pc != STEP_WAIT);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (act == ACT_EMIT && !out_busy) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act == ACT_EMIT && !out_busy) begin
			is_prime_q <= res;
		end
	end

	assign res_valid = res_valid_q;
	assign is_prime  = is_prime_q;

endmodule

// ===== tb/sv/prime_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_result_checker
// watches both channels of the prime tester, predicts each is_prime word by
// its own trial division and compares the words in order
// ----------------------------------------------------------------------------
module prime_result_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cand_valid,
	input  logic                          cand_stall,
	input  logic signed [VALUE_WIDTH-1:0] candidate,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  logic                          is_prime,
	output int                            fail_count,
	output int                            pending_count,
	output int                            checked_count,
	output int                            prime_count
);

	// one candidate and the flag it should give
	typedef struct {
		logic signed [VALUE_WIDTH-1:0] word;
		logic                          flag;
	} verdict_t;

	verdict_t awaited_verdicts[$];
	int       fails   = 0;
	int       checked = 0;
	int       primes  = 0;

	// trial division with the bound taken by division, so no square overflows
	function automatic logic prime_by_division(input logic signed [VALUE_WIDTH-1:0] value);
		longint unsigned n;
		longint unsigned d;
		if (value < 0)
			return 1'b0;
		n = $unsigned(value);
		if (n < 2)
			return 1'b0;
		for (d = 2; d <= n / d; d++) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	initial begin
		fail_count    = 0;
		pending_count = 0;
		checked_count = 0;
		prime_count   = 0;
	end

	// compare each result word with the oldest prediction, then log new candidates
	always @(posedge clk) begin
		verdict_t head;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (awaited_verdicts.size() == 0) begin
					fails++;
					$error("is_prime word %0b arrived with no candidate outstanding",
						is_prime);
				end else begin
					head = awaited_verdicts.pop_front();
					checked++;
					if (head.flag)
						primes++;
					if (is_prime !== head.flag) begin
						fails++;
						$error("is_prime mismatch for candidate %0d: expected %0b, actual %0b",
							head.word, head.flag, is_prime);
					end
				end
			end
			if (cand_valid && !cand_stall) begin
				head.word = candidate;
				head.flag = prime_by_division(candidate);
				awaited_verdicts.push_back(head);
			end
			fail_count    <= fails;
			pending_count <= awaited_verdicts.size();
			checked_count <= checked;
			prime_count   <= primes;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives candidate words into the trial division prime tester under random
// bursts, gaps and output stalls; the checker beside the block judges results
// ----------------------------------------------------------------------------
module tb_top;

	localparam int VALUE_WIDTH     = 32;
	localparam int RANDOM_WORDS    = 70;
	localparam int HOLD_OFF_WORDS  = 8;
	localparam int HOLD_OFF_CYCLES = 1000;
	localparam int DRAIN_CYCLES    = 100;
	localparam int DIRECTED_COUNT  = 22;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          cand_valid = 1'b0;
	logic                          cand_stall;
	logic signed [VALUE_WIDTH-1:0] candidate  = '0;
	logic                          res_valid;
	logic                          res_stall  = 1'b0;
	logic                          is_prime;

	int   fail_count;
	int   pending_count;
	int   checked_count;
	int   prime_count;
	int   burst_left    = 1;
	logic hold_off_req  = 1'b0;
	logic hold_off_done = 1'b0;

	// extremes of the field, tiny values, squares of primes and the top value
	logic [VALUE_WIDTH-1:0] directed_words [DIRECTED_COUNT] = '{
		32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 32'd1, 32'd2, 32'd3,
		32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd10403, 32'd997, 32'd65521,
		32'd65535, 32'h5555_5555, 32'h2AAA_AAAA, 32'h7FFF_FFFE, 32'h7FFF_FFFD,
		32'd1000003, 32'h7FFF_FFFF
	};

	trial_division_prime_test_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand_valid(cand_valid),
		.cand_stall(cand_stall),
		.candidate (candidate),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.is_prime  (is_prime)
	);

	prime_result_checker #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cand_valid   (cand_valid),
		.cand_stall   (cand_stall),
		.candidate    (candidate),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.is_prime     (is_prime),
		.fail_count   (fail_count),
		.pending_count(pending_count),
		.checked_count(checked_count),
		.prime_count  (prime_count)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// offer one word and hold it until taken; bursts end in a random gap
	task automatic send_word(input logic [VALUE_WIDTH-1:0] word);
		int unsigned gap;
		cand_valid <= 1'b1;
		candidate  <= word;
		do @(posedge clk); while (cand_stall);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				cand_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// sender idles until the checker has nothing outstanding
	task automatic wait_drained();
		cand_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	// receiver: one long hold-off on request, otherwise stall stretches of random density
	initial begin
		int unsigned stall_pct;
		int unsigned pattern_left;
		stall_pct    = 0;
		pattern_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
				res_stall <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(20, 120);
					case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 30;
						3: stall_pct = 60;
						default: stall_pct = 90;
					endcase
				end
				pattern_left--;
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// stimulus and verdict
	initial begin
		int unsigned                 sel;
		int unsigned                 factor;
		int unsigned                 multiplier;
		logic [VALUE_WIDTH-1:0]      word;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		foreach (directed_words[i])
			send_word(directed_words[i]);
		wait_drained();

		// long output hold-off with the sender still offering tiny candidates
		hold_off_req = 1'b1;
		repeat (HOLD_OFF_WORDS)
			send_word($urandom_range(0, 20));
		cand_valid <= 1'b0;
		while (!hold_off_done) @(posedge clk);
		wait_drained();

		// random mix, kept mostly small so the divider loop stays short
		repeat (RANDOM_WORDS) begin
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				word = $urandom | 32'h8000_0000;
			end else if (sel < 17) begin
				word = $urandom_range(0, 3);
			end else if (sel < 55) begin
				word = $urandom_range(2, 4095);
			end else if (sel < 65) begin
				word = $urandom_range(4096, 262143);
			end else begin
				// large composite with a small factor, so it ends early
				case ($urandom_range(0, 3))
					0: factor = 2;
					1: factor = 3;
					2: factor = 5;
					default: factor = 7;
				endcase
				multiplier = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF / factor);
				word = multiplier * factor;
			end
			send_word(word);
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d is_prime words, %0d of them prime", checked_count, prime_count);
		$display("covered negatives, 0 to 3, primes, composites, the top value and stalls");
		if (fail_count == 0 && pending_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run limit, well above the slowest correct run
	initial begin
		#(200_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
